### sv/srad_pkg.sv
package srad_pkg;

  // Fixed-point format and field widths
  localparam int FRAC_BITS  = 24;
  localparam int PIX_W      = 32;
  localparam int REG_W      = 31;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  // Datapath widths
  localparam int DIFF_W    = PIX_W + 1;              // neighbor minus center
  localparam int DEN_W     = 64;                     // q0sq * (1 + q0sq)
  localparam int REM_W     = DEN_W + 1;              // shifted remainder
  localparam int COEF_W    = FRAC_BITS + 1;          // coefficient in [0, 1]
  localparam int PROD_W    = COEF_W + DIFF_W;
  localparam int TERM_W    = PROD_W - FRAC_BITS;
  localparam int SUM_W     = TERM_W + 3;             // signed sum of four terms
  localparam int MAG_W     = SUM_W - 1;
  localparam int LAM_SPLIT = 16;
  localparam int LH_W      = REG_W - LAM_SPLIT;
  localparam int A_W       = MAG_W + LH_W;
  localparam int B_W       = MAG_W + LAM_SPLIT;
  localparam int ACC_W     = A_W + 1;
  localparam int UPD_SHIFT = FRAC_BITS + 2 - LAM_SPLIT;
  localparam int UPD_W     = ACC_W - UPD_SHIFT;
  localparam int RES_W     = UPD_W + 2;

  localparam logic [COEF_W-1:0] FX_ONE     = COEF_W'(1) << FRAC_BITS;
  localparam logic [REG_W-1:0]  Q0_RESET   = '0;
  localparam logic [REG_W-1:0]  RATE_RESET = REG_W'(1) << (FRAC_BITS - 1);
  localparam logic [PIX_W-1:0]  PIX_MAX    = {1'b0, {(PIX_W-1){1'b1}}};
  localparam logic [PIX_W-1:0]  PIX_MIN    = {1'b1, {(PIX_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_Q0_SQUARED     = CFG_IDX_W'(0),
    REG_DIFFUSION_RATE = CFG_IDX_W'(1)
  } cfg_reg_e;

  // One coefficient lane in flight through the divider
  typedef struct packed {
    logic              special;
    logic [COEF_W-1:0] spec_val;
    logic [DEN_W-1:0]  rem;
    logic [DEN_W-1:0]  divisor;
    logic [FRAC_BITS-1:0] quo;
  } div_lane_t;

  // One restoring division step: one quotient bit
  function automatic div_lane_t div_step(div_lane_t x);
    div_lane_t        y;
    logic [REM_W-1:0] r2;
    logic [REM_W-1:0] diff;
    logic             ge;
    y    = x;
    r2   = {x.rem, 1'b0};
    diff = r2 - {1'b0, x.divisor};
    ge   = (r2 >= {1'b0, x.divisor});
    y.quo = {x.quo[FRAC_BITS-2:0], ge};
    y.rem = ge ? diff[DEN_W-1:0] : r2[DEN_W-1:0];
    return y;
  endfunction

endpackage

### sv/srad_if.sv
interface srad_pix_if import srad_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] j_center;
  logic [PIX_W-1:0] j_north;
  logic [PIX_W-1:0] j_south;
  logic [PIX_W-1:0] j_west;
  logic [PIX_W-1:0] j_east;
  logic [PIX_W-1:0] q2_center;
  logic             valid_center;
  logic [PIX_W-1:0] q2_south;
  logic             valid_south;
  logic [PIX_W-1:0] q2_east;
  logic             valid_east;
  logic             data_lane;

  modport source (output valid, j_center, j_north, j_south, j_west, j_east, q2_center,
                  valid_center, q2_south, valid_south, q2_east, valid_east, data_lane,
                  input ready);
  modport sink (input valid, j_center, j_north, j_south, j_west, j_east, q2_center,
                valid_center, q2_south, valid_south, q2_east, valid_east, data_lane,
                output ready);
endinterface

interface srad_res_if import srad_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] j_next;

  modport source (output valid, j_next, input ready);
  modport sink (input valid, j_next, output ready);
endinterface

interface srad_cfg_if import srad_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wr_data;

  modport source (output valid, reg_index, wr_data, input ready);
  modport sink (input valid, reg_index, wr_data, output ready);
endinterface

### sv/srad_div_pipe.sv
// Pipelined restoring divider for one coefficient lane, one quotient bit per stage
module srad_div_pipe import srad_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      valid_i,
  input  div_lane_t lane_i,
  output logic      valid_o,
  output div_lane_t lane_o
);

  div_lane_t stage_q [FRAC_BITS];
  logic      vld_q   [FRAC_BITS];

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < FRAC_BITS; i++) vld_q[i] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
      for (int i = 1; i < FRAC_BITS; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  // Advance one division step per stage
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q[0] <= div_step(lane_i);
      for (int i = 1; i < FRAC_BITS; i++) stage_q[i] <= div_step(stage_q[i-1]);
    end
  end

  assign valid_o = vld_q[FRAC_BITS-1];
  assign lane_o  = stage_q[FRAC_BITS-1];

  // Remainder of a real division stays below the divisor
  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !lane_o.special) |-> (lane_o.rem < lane_o.divisor))
    else $error("divider remainder not below divisor");

endmodule

### sv/srad_diffusion_update.sv
// SRAD pixel update. One pixel beat is accepted per clock and one result beat comes
// out for each, in order; each diffusion coefficient is formed by a divider, one
// quotient bit per stage. The whole pipeline holds while a finished result waits on
// res_o.ready. Values are signed Q8.24; j_next saturates to 32 bits and is zero for a
// padding lane. Write q0_squared (index 0) and diffusion_rate (index 1) on cfg_i only
// while no pixel is in flight; other indexes are ignored.
module srad_diffusion_update import srad_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  srad_cfg_if.sink cfg_i,
  srad_pix_if.sink pix_i,
  srad_res_if.source res_o
);

  typedef struct packed {
    logic [PIX_W-1:0] jc;
    logic [PIX_W-1:0] jn;
    logic [PIX_W-1:0] js;
    logic [PIX_W-1:0] jw;
    logic [PIX_W-1:0] je;
    logic [PIX_W-1:0] q2c;
    logic             vc;
    logic [PIX_W-1:0] q2s;
    logic             vs;
    logic [PIX_W-1:0] q2e;
    logic             ve;
    logic             lane;
  } pix_t;

  typedef struct packed {
    logic              lane;
    logic [PIX_W-1:0]  jc;
    logic [DIFF_W-1:0] dn;
    logic [DIFF_W-1:0] ds;
    logic [DIFF_W-1:0] dw;
    logic [DIFF_W-1:0] de;
  } side_t;

  logic en;

  // Configuration registers
  logic [REG_W-1:0] q0_q;
  logic [REG_W-1:0] q0_d;
  logic [REG_W-1:0] rate_q;
  logic [DEN_W-1:0] den_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q0_q   <= Q0_RESET;
      rate_q <= RATE_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.reg_index)
        REG_Q0_SQUARED:     q0_q   <= cfg_i.wr_data[REG_W-1:0];
        REG_DIFFUSION_RATE: rate_q <= cfg_i.wr_data[REG_W-1:0];
        default: ;
      endcase
    end
  end

  // Next q0_squared, so the denominator follows a write in the same cycle
  always_comb begin
    q0_d = q0_q;
    if (cfg_i.valid && (cfg_i.reg_index == REG_Q0_SQUARED)) begin
      q0_d = cfg_i.wr_data[REG_W-1:0];
    end
  end

  // Coefficient denominator, recomputed from the next q0_squared every cycle
  always_ff @(posedge clk_i) begin
    den_q <= DEN_W'(q0_d) * DEN_W'(q0_d) + (DEN_W'(q0_d) << FRAC_BITS);
  end

  // Stall the whole pipe while the output holds an untaken beat
  logic vo_q;
  assign en          = !vo_q || res_o.ready;
  assign pix_i.ready = en;

  // Stage 0: capture input beat
  logic v0_q;
  pix_t in_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v0_q <= 1'b0;
    else if (en) v0_q <= pix_i.valid;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_q <= '{jc: pix_i.j_center, jn: pix_i.j_north, js: pix_i.j_south,
                jw: pix_i.j_west, je: pix_i.j_east, q2c: pix_i.q2_center,
                vc: pix_i.valid_center, q2s: pix_i.q2_south, vs: pix_i.valid_south,
                q2e: pix_i.q2_east, ve: pix_i.valid_east, lane: pix_i.data_lane};
    end
  end

  // Set up one coefficient: special value or divider operands
  function automatic div_lane_t coef_prep(logic [PIX_W-1:0] q2, logic vld,
                                          logic [REG_W-1:0] q0, logic [DEN_W-1:0] den);
    div_lane_t                x;
    logic signed [DIFF_W-1:0] delta;
    logic [DIFF_W-1:0]        neg;
    logic [DEN_W-1:0]         negsh;
    x       = '0;
    delta   = $signed({q2[PIX_W-1], q2}) - $signed({2'b00, q0});
    neg     = DIFF_W'(-delta);
    negsh   = DEN_W'(neg) << FRAC_BITS;
    x.rem   = den;
    x.divisor = den + (DEN_W'(unsigned'(delta)) << FRAC_BITS);
    if (!vld || (q0 == '0)) begin
      x.special  = 1'b1;
      x.spec_val = FX_ONE;
    end else if (delta <= 0) begin
      x.special  = 1'b1;
      x.spec_val = (negsh > den) ? '0 : FX_ONE;
    end
    return x;
  endfunction

  function automatic logic [DIFF_W-1:0] diff(logic [PIX_W-1:0] a, logic [PIX_W-1:0] c);
    return {a[PIX_W-1], a} - {c[PIX_W-1], c};
  endfunction

  // Stage 1: differences and divider setup
  logic      v1_q;
  side_t     side1_q;
  div_lane_t prep_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en) v1_q <= v0_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side1_q   <= '{lane: in_q.lane, jc: in_q.jc, dn: diff(in_q.jn, in_q.jc),
                     ds: diff(in_q.js, in_q.jc), dw: diff(in_q.jw, in_q.jc),
                     de: diff(in_q.je, in_q.jc)};
      prep_q[0] <= coef_prep(in_q.q2c, in_q.vc, q0_q, den_q);
      prep_q[1] <= coef_prep(in_q.q2s, in_q.vs, q0_q, den_q);
      prep_q[2] <= coef_prep(in_q.q2e, in_q.ve, q0_q, den_q);
    end
  end

  // Divider lanes: center, south, east
  logic      vd [3];
  div_lane_t dq [3];

  for (genvar g = 0; g < 3; g++) begin : g_div
    srad_div_pipe u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (v1_q),
      .lane_i  (prep_q[g]),
      .valid_o (vd[g]),
      .lane_o  (dq[g])
    );
  end

  // Carry differences alongside the divider
  side_t side_d_q [FRAC_BITS];

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_d_q[0] <= side1_q;
      for (int i = 1; i < FRAC_BITS; i++) side_d_q[i] <= side_d_q[i-1];
    end
  end

  side_t side_dv;
  assign side_dv = side_d_q[FRAC_BITS-1];

  // Stage 3: coefficients and products
  logic [COEF_W-1:0] cc, cs, ce;
  assign cc = dq[0].special ? dq[0].spec_val : {1'b0, dq[0].quo};
  assign cs = dq[1].special ? dq[1].spec_val : {1'b0, dq[1].quo};
  assign ce = dq[2].special ? dq[2].spec_val : {1'b0, dq[2].quo};

  function automatic logic [DIFF_W-1:0] absd(logic [DIFF_W-1:0] d);
    return d[DIFF_W-1] ? -d : d;
  endfunction

  logic              v3_q;
  logic              lane3_q;
  logic [PIX_W-1:0]  jc3_q;
  logic [PROD_W-1:0] prod_q [4];
  logic              neg3_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (en) v3_q <= vd[0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lane3_q   <= side_dv.lane;
      jc3_q     <= side_dv.jc;
      prod_q[0] <= PROD_W'(cc) * PROD_W'(absd(side_dv.dn));
      prod_q[1] <= PROD_W'(cs) * PROD_W'(absd(side_dv.ds));
      prod_q[2] <= PROD_W'(cc) * PROD_W'(absd(side_dv.dw));
      prod_q[3] <= PROD_W'(ce) * PROD_W'(absd(side_dv.de));
      neg3_q[0] <= side_dv.dn[DIFF_W-1];
      neg3_q[1] <= side_dv.ds[DIFF_W-1];
      neg3_q[2] <= side_dv.dw[DIFF_W-1];
      neg3_q[3] <= side_dv.de[DIFF_W-1];
    end
  end

  // Stage 4: truncate each term toward zero and sum
  function automatic logic signed [SUM_W-1:0] term(logic [PROD_W-1:0] p, logic neg);
    logic signed [SUM_W-1:0] t;
    t = $signed(SUM_W'(p[PROD_W-1:FRAC_BITS]));
    return neg ? -t : t;
  endfunction

  logic                    v4_q;
  logic                    lane4_q;
  logic [PIX_W-1:0]        jc4_q;
  logic signed [SUM_W-1:0] sum4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else if (en) v4_q <= v3_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lane4_q <= lane3_q;
      jc4_q   <= jc3_q;
      sum4_q  <= term(prod_q[0], neg3_q[0]) + term(prod_q[1], neg3_q[1])
               + term(prod_q[2], neg3_q[2]) + term(prod_q[3], neg3_q[3]);
    end
  end

  // Stage 5: magnitude times lambda, split in two partial products
  logic [SUM_W-1:0] sum_abs;
  logic [MAG_W-1:0] mag;
  assign sum_abs = sum4_q[SUM_W-1] ? unsigned'(-sum4_q) : unsigned'(sum4_q);
  assign mag     = sum_abs[MAG_W-1:0];

  logic             v5_q;
  logic             lane5_q;
  logic             neg5_q;
  logic [PIX_W-1:0] jc5_q;
  logic [A_W-1:0]   a_q;
  logic [B_W-1:0]   b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else if (en) v5_q <= v4_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lane5_q <= lane4_q;
      neg5_q  <= sum4_q[SUM_W-1];
      jc5_q   <= jc4_q;
      a_q     <= A_W'(mag) * A_W'(rate_q[REG_W-1:LAM_SPLIT]);
      b_q     <= B_W'(mag) * B_W'(rate_q[LAM_SPLIT-1:0]);
    end
  end

  // Stage 6: scale, update center, saturate
  logic [ACC_W-1:0]        acc;
  logic [UPD_W-1:0]        upd;
  logic signed [RES_W-1:0] jc_ext, res;
  logic [PIX_W-1:0]        sat;

  always_comb begin
    acc    = ACC_W'(a_q) + ACC_W'(b_q[B_W-1:LAM_SPLIT]);
    upd    = acc[ACC_W-1:UPD_SHIFT];
    jc_ext = RES_W'($signed(jc5_q));
    res    = neg5_q ? jc_ext - $signed({2'b00, upd}) : jc_ext + $signed({2'b00, upd});
    if (res > RES_W'($signed(PIX_MAX)))      sat = PIX_MAX;
    else if (res < RES_W'($signed(PIX_MIN))) sat = PIX_MIN;
    else                                     sat = res[PIX_W-1:0];
  end

  logic             lane_o_q;
  logic [PIX_W-1:0] out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vo_q <= 1'b0;
    else if (en) vo_q <= v5_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lane_o_q <= lane5_q;
      out_q    <= lane5_q ? sat : '0;
    end
  end

  assign res_o.valid  = vo_q;
  assign res_o.j_next = out_q;

  // Divider lanes advance in lockstep
  a_div_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vd[0] == vd[1]) && (vd[0] == vd[2]))
    else $error("divider lanes out of step");

  // Coefficients never leave [0, 1]
  a_coef_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vd[0] |-> ((cc <= FX_ONE) && (cs <= FX_ONE) && (ce <= FX_ONE)))
    else $error("coefficient above one");

  // Padding beats leave as zero
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vo_q && !lane_o_q) |-> (out_q == '0))
    else $error("padding beat not zero");

  // A stalled pipe keeps its last stage
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vo_q && !res_o.ready) |=> (vo_q && $stable(out_q) && $stable(v5_q)))
    else $error("pipeline moved while stalled");

endmodule
